@@ src/rar_pkg.sv @@
`default_nettype none
package rar_pkg;
   localparam int Width = 32;
   localparam int DenW = 31;
   localparam int WideW = 64;
   localparam int StW = 2;

   localparam logic [StW-1:0] ST_OK = 2'd0;
   localparam logic [StW-1:0] ST_ZERO_DEN = 2'd1;
   localparam logic [StW-1:0] ST_OVERFLOW = 2'd2;

   // request word
   typedef struct packed {
      logic signed [Width-1:0] a_numerator;
      logic [DenW-1:0] a_denominator;
      logic signed [Width-1:0] b_numerator;
      logic [DenW-1:0] b_denominator;
   } req_word_type;

   // response word
   typedef struct packed {
      logic signed [Width-1:0] sum_numerator;
      logic [DenW-1:0] sum_denominator;
      logic [StW-1:0] status;
   } rsp_word_type;

   // divider control and status
   typedef struct packed {
      logic start;
      logic [WideW-1:0] dividend;
      logic [WideW-1:0] divisor;
   } div_cmd_type;

   typedef struct packed {
      logic done;
      logic [WideW-1:0] quotient;
      logic [WideW-1:0] remainder;
   } div_res_type;
endpackage
`default_nettype wire

@@ src/rar_if.sv @@
`default_nettype none
interface rar_req_if (input wire logic clock);
   import rar_pkg::*;
   logic valid;
   logic ready;
   req_word_type word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

interface rar_rsp_if (input wire logic clock);
   import rar_pkg::*;
   logic valid;
   logic ready;
   rsp_word_type word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface
`default_nettype wire

@@ src/rar_div.sv @@
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module rar_div (
   input wire logic clock,
   input wire logic reset,
   input wire rar_pkg::div_cmd_type cmd,
   output rar_pkg::div_res_type res
);
   import rar_pkg::*;

   logic [WideW-1:0] quo_ff, quo_in;
   logic [WideW-1:0] rem_ff, rem_in;
   logic [WideW-1:0] dvs_ff, dvs_in;
   logic [6:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic done_ff, done_in;
   logic [WideW:0] trial;

   // one shift-subtract step
   always_comb begin
      quo_in = quo_ff;
      rem_in = rem_ff;
      dvs_in = dvs_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff, quo_ff[WideW-1]} - {1'b0, dvs_ff};
      if (cmd.start) begin
         quo_in = cmd.dividend;
         rem_in = '0;
         dvs_in = cmd.divisor;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial[WideW]) begin
            rem_in = {rem_ff[WideW-2:0], quo_ff[WideW-1]};
            quo_in = {quo_ff[WideW-2:0], 1'b0};
         end else begin
            rem_in = trial[WideW-1:0];
            quo_in = {quo_ff[WideW-2:0], 1'b1};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'(WideW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      if (reset) begin
         cnt_ff <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign res.done = done_ff;
   assign res.quotient = quo_ff;
   assign res.remainder = rem_ff;
endmodule
`default_nettype wire

@@ src/rational_add_reduce.sv @@
`default_nettype none
// Each Euclid step and each division runs on the single shared 64-bit radix-2
// divider, so the time to a result is data dependent: it grows with k1 and k2, the
// remainder steps of the two gcds (k1 at most ~46, k2 at most ~92); a zero denominator
// gives its result in the cycle after acceptance.
// One item at a time: req ready only in idle; result held until taken.
// Reset (synchronous, active high) returns the sequencer to idle and drops rsp valid.
module rational_add_reduce (
   input wire logic clock,
   input wire logic reset,
   rar_req_if.sink req,
   rar_rsp_if.source rsp
);
   import rar_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_G1    = 9'b000000010,
      S_LCM   = 9'b000000100,
      S_M1    = 9'b000001000,
      S_MUL   = 9'b000010000,
      S_M2    = 9'b000100000,
      S_G2    = 9'b001000000,
      S_RED   = 9'b010000000,
      S_OUT   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;
   logic [2:0] phase_ff, phase_in;
   req_word_type inw_ff, inw_in;
   logic [WideW-1:0] x_ff, x_in, y_ff, y_in;
   logic [WideW-1:0] lcm_ff, lcm_in, m1_ff, m1_in, acc_ff, acc_in;
   logic [WideW-1:0] mag_ff, mag_in;
   logic neg_ff, neg_in;
   rsp_word_type out_ff, out_in;
   logic vld_ff, vld_in;
   div_cmd_type cmd;
   div_res_type res;
   logic [WideW-1:0] prod;
   logic [WideW-1:0] mulop;
   logic signed [Width-1:0] nsel;
   logic [WideW-1:0] nmax;
   logic [WideW-1:0] rmag;

   rar_div u_div (.clock(clock), .reset(reset), .cmd(cmd), .res(res));

   assign nmax = (WideW'(1) << (Width - 1)) - WideW'(1);
   // one 32-bit signed x 32-bit unsigned product a cycle, nsel selects the numerator
   assign prod = WideW'($signed(nsel) * $signed({1'b0, mulop[Width-1:0]}));

   // sequencer
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      inw_in = inw_ff;
      x_in = x_ff; y_in = y_ff;
      lcm_in = lcm_ff; m1_in = m1_ff; acc_in = acc_ff;
      mag_in = mag_ff; neg_in = neg_ff;
      out_in = out_ff;
      vld_in = vld_ff;
      cmd = '0;
      nsel = inw_ff.a_numerator;
      mulop = m1_ff;
      rmag = '0;
      if (vld_ff && rsp.ready) vld_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req.valid && !vld_ff) begin
               inw_in = req.word;
               if (req.word.a_denominator == '0 || req.word.b_denominator == '0) begin
                  out_in = '{sum_numerator: '0, sum_denominator: '0, status: ST_ZERO_DEN};
                  vld_in = 1'b1;
               end else begin
                  x_in = WideW'(req.word.a_denominator);
                  y_in = WideW'(req.word.b_denominator);
                  phase_in = '0;
                  state_in = S_G1;
               end
            end
         end
         // Euclid on x and y (denominators in S_G1, lcm and sum magnitude in S_G2): x mod y repeatedly
         S_G1, S_G2: begin
            if (phase_ff == 3'd0) begin
               if (y_ff == '0) begin
                  if (state_ff == S_G1) begin
                     cmd = '{start: 1'b1, dividend: WideW'(inw_ff.a_denominator),
                             divisor: x_ff};
                     state_in = S_LCM;
                  end else begin
                     cmd = '{start: 1'b1, dividend: mag_ff, divisor: x_ff};
                     state_in = S_RED;
                  end
                  phase_in = '0;
               end else begin
                  cmd = '{start: 1'b1, dividend: x_ff, divisor: y_ff};
                  phase_in = 3'd1;
               end
            end else if (res.done) begin
               x_in = y_ff;
               y_in = res.remainder;
               phase_in = '0;
            end
         end
         // lcm = (d1/g)*d2 ; then m1 = lcm/d1
         S_LCM: begin
            if (res.done) begin
               lcm_in = WideW'(res.quotient[DenW-1:0] * inw_ff.b_denominator);
               m1_in = WideW'(inw_ff.b_denominator);
               cmd = '0;
               state_in = S_M1;
               phase_in = '0;
            end
         end
         S_M1: begin
            if (phase_ff == 3'd0) begin
               cmd = '{start: 1'b1, dividend: lcm_ff, divisor: WideW'(inw_ff.a_denominator)};
               phase_in = 3'd1;
            end else if (res.done) begin
               m1_in = res.quotient;
               state_in = S_MUL;
               phase_in = '0;
            end
         end
         S_MUL: begin
            acc_in = prod;
            state_in = S_M2;
         end
         S_M2: begin
            if (phase_ff == 3'd0) begin
               cmd = '{start: 1'b1, dividend: lcm_ff, divisor: WideW'(inw_ff.b_denominator)};
               phase_in = 3'd1;
            end else if (phase_ff == 3'd1) begin
               if (res.done) begin
                  m1_in = res.quotient;
                  phase_in = 3'd2;
               end
            end else begin
               nsel = inw_ff.b_numerator;
               acc_in = acc_ff + prod;
               neg_in = acc_in[WideW-1];
               mag_in = acc_in[WideW-1] ? (WideW'(0) - acc_in) : acc_in;
               x_in = lcm_ff;
               y_in = mag_in;
               phase_in = '0;
               state_in = S_G2;
            end
         end
         // mag/g first, then lcm/g
         S_RED: begin
            if (phase_ff == 3'd0) begin
               if (res.done) begin
                  mag_in = res.quotient;
                  cmd = '{start: 1'b1, dividend: lcm_ff, divisor: x_ff};
                  phase_in = 3'd1;
               end
            end else if (res.done) begin
               lcm_in = res.quotient;
               state_in = S_OUT;
               phase_in = '0;
            end
         end
         S_OUT: begin
            rmag = neg_ff ? (WideW'(0) - mag_ff) : mag_ff;
            if (lcm_ff > nmax || (neg_ff && mag_ff > nmax + WideW'(1)) ||
                (!neg_ff && mag_ff > nmax)) begin
               out_in = '{sum_numerator: '0, sum_denominator: '0, status: ST_OVERFLOW};
            end else begin
               out_in = '{sum_numerator: rmag[Width-1:0],
                          sum_denominator: lcm_ff[DenW-1:0], status: ST_OK};
            end
            vld_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      inw_ff <= inw_in;
      x_ff <= x_in; y_ff <= y_in;
      lcm_ff <= lcm_in; m1_ff <= m1_in; acc_ff <= acc_in;
      mag_ff <= mag_in; neg_ff <= neg_in;
      out_ff <= out_in;
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= '0;
         vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         vld_ff <= vld_in;
      end
   end

   assign req.ready = (state_ff == S_IDLE) && !vld_ff;
   assign rsp.valid = vld_ff;
   assign rsp.word = out_ff;
endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
`default_nettype none
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import rar_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #6 clock = ~clock;

   rar_req_if req (clock);
   rar_rsp_if rsp (clock);

   rational_add_reduce dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source)
   );

   // sums waiting to come out, oldest first
   rsp_word_type sum_queue[$];
   int errors = 0;
   bit stim_done = 1'b0;
   bit long_hold = 1'b0;

   // directed table: operands plus a typed-in result where it is obvious
   typedef struct {
      logic signed [31:0] an;
      logic [30:0] ad;
      logic signed [31:0] bn;
      logic [30:0] bd;
      bit known;
      rsp_word_type res;
   } dir_row_type;

   localparam int NDIR = 22;
   dir_row_type dir_table[NDIR];

   // Euclid on magnitudes
   function automatic longint unsigned gcd64(longint unsigned x, longint unsigned y);
      longint unsigned t;
      while (y != 0) begin
         t = x % y;
         x = y;
         y = t;
      end
      return x;
   endfunction

   function automatic rsp_word_type rational_sum(req_word_type w);
      rsp_word_type r;
      longint unsigned g, lcm, mag, rden;
      longint total;
      longint n1, n2;
      bit neg;
      r = '0;
      if (w.a_denominator == 0 || w.b_denominator == 0) begin
         r.status = ST_ZERO_DEN;
         return r;
      end
      n1 = longint'(w.a_numerator);
      n2 = longint'(w.b_numerator);
      g = gcd64(w.a_denominator, w.b_denominator);
      lcm = (64'(w.a_denominator) / g) * w.b_denominator;
      total = n1 * longint'(lcm / w.a_denominator) + n2 * longint'(lcm / w.b_denominator);
      neg = total < 0;
      mag = neg ? -total : total;
      g = gcd64(mag, lcm);
      mag = mag / g;
      rden = lcm / g;
      if (rden > 64'h7FFF_FFFF || (neg && mag > 64'h8000_0000) ||
          (!neg && mag > 64'h7FFF_FFFF)) begin
         r.status = ST_OVERFLOW;
         return r;
      end
      r.sum_numerator = neg ? -mag[31:0] : mag[31:0];
      r.sum_denominator = rden[30:0];
      r.status = ST_OK;
      return r;
   endfunction

   function automatic rsp_word_type mk(logic signed [31:0] n, logic [30:0] d,
                                       logic [1:0] s);
      rsp_word_type r;
      r.sum_numerator = n;
      r.sum_denominator = d;
      r.status = s;
      return r;
   endfunction

   // random operands: mostly small denominators, some wide, some zero
   function automatic logic [30:0] rand_den();
      case ($urandom_range(0, 9))
         0: return 31'($urandom_range(0, 1));
         1, 2: return 31'($urandom);
         3: return 31'h7FFF_FFFF - 31'($urandom_range(0, 3));
         default: return 31'($urandom_range(1, 1000));
      endcase
   endfunction

   function automatic logic [31:0] rand_num();
      case ($urandom_range(0, 5))
         0: return 32'($urandom_range(0, 20)) - 32'd10;
         1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_word_type rand_word();
      req_word_type w;
      w.a_numerator = rand_num();
      w.a_denominator = rand_den();
      w.b_numerator = rand_num();
      w.b_denominator = rand_den();
      return w;
   endfunction

   // offer one word, hold until accepted
   task automatic send_word(req_word_type w, bit known, rsp_word_type res);
      req.valid <= 1'b1;
      req.word <= w;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      sum_queue.push_back(known ? res : rational_sum(w));
   endtask

   initial begin
      rsp_word_type z;
      z = '0;
      dir_table[0] = '{1, 2, 1, 3, 1, mk(5, 6, ST_OK)};
      dir_table[1] = '{1, 2, -1, 2, 1, mk(0, 1, ST_OK)};
      dir_table[2] = '{5, 0, 1, 1, 1, mk(0, 0, ST_ZERO_DEN)};
      dir_table[3] = '{5, 1, 1, 0, 1, mk(0, 0, ST_ZERO_DEN)};
      dir_table[4] = '{0, 0, 0, 0, 1, mk(0, 0, ST_ZERO_DEN)};
      dir_table[5] = '{32'h7FFF_FFFF, 1, 1, 1, 1, mk(0, 0, ST_OVERFLOW)};
      dir_table[6] = '{32'h8000_0000, 1, -1, 1, 1, mk(0, 0, ST_OVERFLOW)};
      dir_table[7] = '{32'h8000_0000, 1, 0, 1, 1, mk(32'h8000_0000, 1, ST_OK)};
      dir_table[8] = '{32'h7FFF_FFFF, 1, 0, 1, 1, mk(32'h7FFF_FFFF, 1, ST_OK)};
      dir_table[9] = '{1, 31'h7FFF_FFFF, 1, 31'h7FFF_FFFE, 0, z};
      dir_table[10] = '{32'h8000_0000, 31'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 0, z};
      dir_table[11] = '{32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 0, z};
      dir_table[12] = '{6, 4, 2, 4, 1, mk(2, 1, ST_OK)};
      dir_table[13] = '{-3, 9, 0, 5, 1, mk(-1, 3, ST_OK)};
      dir_table[14] = '{0, 7, 0, 3, 1, mk(0, 1, ST_OK)};
      dir_table[15] = '{3, 4, 5, 1, 1, mk(23, 4, ST_OK)};
      dir_table[16] = '{-1, 31'h7FFF_FFFF, -1, 31'h7FFF_FFFF, 0, z};
      dir_table[17] = '{1, 65536, 1, 65537, 0, z};
      dir_table[18] = '{32'h5555_5555, 31'h2AAA_AAAA, 32'hAAAA_AAAA, 31'h5555_5555, 0, z};
      dir_table[19] = '{-7, 1, -5, 1, 1, mk(-12, 1, ST_OK)};
      dir_table[20] = '{1, 46341, 1, 46349, 0, z};
      dir_table[21] = '{32'h4000_0000, 1, 32'h4000_0000, 1, 1, mk(0, 0, ST_OVERFLOW)};
   end

   // stimulus
   initial begin
      req_word_type w;
      int burst, gap, n;
      req.valid = 1'b0;
      req.word = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < NDIR; i++) begin
         w.a_numerator = dir_table[i].an;
         w.a_denominator = dir_table[i].ad;
         w.b_numerator = dir_table[i].bn;
         w.b_denominator = dir_table[i].bd;
         if (dir_table[i].known && dir_table[i].res != rational_sum(w)) begin
            $error("table row %0d disagrees with predictor", i);
            errors++;
         end
         send_word(w, dir_table[i].known, dir_table[i].res);
      end
      // pause until everything has drained
      req.valid <= 1'b0;
      while (sum_queue.size() != 0) @(posedge clock);
      long_hold = 1'b1;
      n = 0;
      while (n < 1600) begin
         burst = $urandom_range(1, 12);
         for (int k = 0; k < burst && n < 1600; k++) begin
            w = rand_word();
            send_word(w, 1'b0, '0);
            n++;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 400);
         if (gap != 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req.valid <= 1'b0;
      stim_done = 1'b1;
   end

   // receiver: stall pattern, with one long hold-off once random traffic starts
   initial begin
      int phase;
      bit held;
      rsp.ready = 1'b0;
      phase = 0;
      held = 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (long_hold && !held) begin
            held = 1'b1;
            rsp.ready <= 1'b0;
            repeat (3000) @(posedge clock);
         end
         phase++;
         if ((phase / 500) % 3 == 0) rsp.ready <= 1'b1;
         else rsp.ready <= ($urandom_range(0, 3) != 0);
         @(posedge clock);
      end
   end

   // compare sums as they leave
   always @(posedge clock) begin
      rsp_word_type e;
      if (!reset && rsp.valid && rsp.ready) begin
         if (sum_queue.size() == 0) begin
            $error("sum word with nothing expected");
            errors++;
         end else begin
            e = sum_queue.pop_front();
            if (rsp.word.sum_numerator !== e.sum_numerator) begin
               $error("sum_numerator exp %0d got %0d", e.sum_numerator,
                      rsp.word.sum_numerator);
               errors++;
            end
            if (rsp.word.sum_denominator !== e.sum_denominator) begin
               $error("sum_denominator exp %0d got %0d", e.sum_denominator,
                      rsp.word.sum_denominator);
               errors++;
            end
            if (rsp.word.status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp.word.status);
               errors++;
            end
         end
      end
   end

   // end of run
   initial begin
      wait (stim_done);
      while (sum_queue.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0 && sum_queue.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   // watchdog: ~1620 words at the worst-case time per word is about 190 ms, plus stalls
   initial begin
      #1000ms;
      $display("CHECK FAILED");
      $finish;
   end
endmodule
`default_nettype wire
